// ===== sv/itp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    // Default operator stack depth
    localparam int STACK_DEPTH_DEF = 32;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // Precedence levels
    localparam logic [1:0] PREC_POW  = 2'd3;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_NONE = 2'd0;

    typedef enum logic [2:0] {
        KIND_SKIP,
        KIND_ALNUM,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_OP,
        KIND_END
    } char_kind_t;

    // Decision of the compare unit for the current stack top
    typedef struct packed {
        logic pop;        // emit and remove the top entry
        logic drop_open;  // discard the matching open parenthesis
    } pop_ctl_t;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = PREC_NONE;
        if (c == CH_CARET) p = PREC_POW;
        else if (c == CH_STAR || c == CH_SLASH) p = PREC_MUL;
        else if (c == CH_PLUS || c == CH_MINUS) p = PREC_ADD;
        return p;
    endfunction

    function automatic char_kind_t classify(input logic [7:0] c);
        char_kind_t k;
        k = KIND_OP;
        if (c == CH_NUL) k = KIND_END;
        else if (c == CH_SPACE || c == CH_TAB || c == CH_LF) k = KIND_SKIP;
        else if ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
                 (c >= CH_LA && c <= CH_LZ)) k = KIND_ALNUM;
        else if (c == CH_OPEN) k = KIND_OPEN;
        else if (c == CH_CLOSE) k = KIND_CLOSE;
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== sv/infix_to_postfix_converter_top.sv =====
// Infix to postfix converter (shunting-yard), one character word per input.
// Input channel: in_char with in_valid / in_stall. A word is taken when
// in_valid is high and in_stall is low. Output channel: out_char, run_last,
// expr_done, overflowed with out_valid / out_stall, taken the same way.
// Blanks are dropped, letters and digits pass through, parentheses and
// operators go through a STACK_DEPTH-entry operator stack held in a
// single-port-write, registered-read memory. A zero word flushes the stack
// and ends with a zero terminator word marked expr_done.
// Sequencing: a skipped or '(' word is taken in the idle state; a letter or
// digit passes through the flush state; ')', operators and zero go through
// the eval state, popping entries, then flush if anything is emitted. Each
// pop is one read of the stack memory followed by one decision of the shared
// precedence compare unit. in_stall is high while a word is in progress.
// Output is registered; a stall on out_stall holds the word and the
// sequencer waits until the output register frees up.
// Reset (rst_n low, asynchronous) empties the stack, clears the overflow
// flag and drops any pending output word. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_top
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_char,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic [7:0]      out_char,
    output logic            run_last,
    output logic            expr_done,
    output logic            overflowed,
    output logic            out_valid,
    input  wire logic       out_stall
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    state_t     state_reg, state_next;
    char_kind_t kind_reg, kind_next;
    logic [7:0] cur_reg, cur_next;
    logic [CW-1:0] count_reg, count_next;
    logic       ovf_reg, ovf_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_char_reg, pend_char_next;
    logic       pend_done_reg, pend_done_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       run_last_reg, run_last_next;
    logic       expr_done_reg, expr_done_next;
    logic       overflowed_reg, overflowed_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          have_top;
    logic          full;
    logic          out_free;
    char_kind_t    in_kind;
    pop_ctl_t      ctl;

    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    itp_pop_unit u_pop (
        .kind    (kind_reg),
        .cur_char(cur_reg),
        .have_top(have_top),
        .top_char(rd_data),
        .ctl     (ctl)
    );

    assign have_top = (count_reg != '0);
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign out_free = !out_valid_reg || !out_stall;
    assign in_kind  = classify(in_char);
    assign in_stall = (state_reg != ST_IDLE);

    // Sequence one input word: classify, pop through the compare unit, push
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_char_next   = out_char_reg;
        run_last_next   = run_last_reg;
        expr_done_next  = expr_done_reg;
        overflowed_next = overflowed_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = cur_reg;
        rd_en           = 1'b0;
        rd_addr         = AW'(count_reg - CW'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = in_kind;
                    cur_next  = in_char;
                    unique case (in_kind)
                        KIND_SKIP:
                        begin
                            state_next = ST_IDLE;
                        end
                        KIND_ALNUM:
                        begin
                            pend_valid_next = 1'b1;
                            pend_char_next  = in_char;
                            pend_done_next  = 1'b0;
                            state_next      = ST_FLUSH;
                        end
                        KIND_OPEN:
                        begin
                            wr_data = in_char;
                            if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            // fetch the top entry for the compare unit
                            rd_en      = have_top;
                            state_next = ST_EVAL;
                        end
                    endcase
                end
            end

            ST_EVAL:
            begin
                if (ctl.pop)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_char_next   = pend_char_reg;
                            run_last_next   = 1'b0;
                            expr_done_next  = pend_done_reg;
                            overflowed_next = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_char_next  = rd_data;
                        pend_done_next  = 1'b0;
                        count_next      = count_reg - CW'(1);
                        rd_en           = 1'b1;
                        rd_addr         = AW'(count_reg - CW'(2));
                    end
                end
                else
                begin
                    unique case (kind_reg)
                        KIND_END:
                        begin
                            if (!pend_valid_reg || out_free)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_char_next   = pend_char_reg;
                                    run_last_next   = 1'b0;
                                    expr_done_next  = pend_done_reg;
                                    overflowed_next = ovf_reg;
                                end
                                pend_valid_next = 1'b1;
                                pend_char_next  = CH_NUL;
                                pend_done_next  = 1'b1;
                                state_next      = ST_FLUSH;
                            end
                        end
                        KIND_CLOSE:
                        begin
                            if (ctl.drop_open)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                        end
                        KIND_OP:
                        begin
                            if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_FLUSH:
            begin
                // hand the last word of this input to the output register
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = pend_char_reg;
                    run_last_next   = 1'b1;
                    expr_done_next  = pend_done_reg;
                    overflowed_next = ovf_reg;
                    pend_valid_next = 1'b0;
                    if (pend_done_reg)
                    begin
                        ovf_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= KIND_SKIP;
            cur_reg        <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= '0;
            pend_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            run_last_reg   <= 1'b0;
            expr_done_reg  <= 1'b0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            cur_reg        <= cur_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            pend_char_reg  <= pend_char_next;
            pend_done_reg  <= pend_done_next;
            out_valid_reg  <= out_valid_next;
            out_char_reg   <= out_char_next;
            run_last_reg   <= run_last_next;
            expr_done_reg  <= expr_done_next;
            overflowed_reg <= overflowed_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign run_last   = run_last_reg;
    assign expr_done  = expr_done_reg;
    assign overflowed = overflowed_reg;

endmodule

`default_nettype wire

// ===== sv/itp_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itp_stack
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [STACK_DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/itp_pop_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itp_pop_unit
    import itp_pkg::*;
(
    input  wire char_kind_t kind,
    input  wire logic [7:0] cur_char,
    input  wire logic       have_top,
    input  wire logic [7:0] top_char,
    output pop_ctl_t        ctl
);

    logic [1:0] prec_cur;
    logic [1:0] prec_top;
    logic       top_open;
    logic       prec_pop;

    // Compare incoming operator against the stack top
    always_comb
    begin
        prec_cur = prec_of(cur_char);
        prec_top = prec_of(top_char);
        top_open = (top_char == CH_OPEN);
        prec_pop = (prec_top > prec_cur) ||
                   ((prec_top == prec_cur) && (cur_char != CH_CARET));
        ctl.pop       = 1'b0;
        ctl.drop_open = 1'b0;
        unique case (kind)
            KIND_END:   ctl.pop = have_top;
            KIND_CLOSE:
            begin
                ctl.pop       = have_top && !top_open;
                ctl.drop_open = have_top && top_open;
            end
            KIND_OP:    ctl.pop = have_top && !top_open && prec_pop;
            default:    ctl.pop = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/itp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic [7:0] in_char,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] out_char,
    input wire logic       run_last,
    input wire logic       expr_done,
    input wire logic       overflowed,
    input wire logic       out_valid,
    input wire logic       out_stall
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) &&
        $stable(run_last) && $stable(expr_done) && $stable(overflowed))
        else $error("output word changed under stall");

    // Terminator is a zero word and closes its input's run
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expr_done |-> out_char == 8'h00 && run_last)
        else $error("terminator word malformed");

    // End of expression always keeps the block busy for the flush
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_char == 8'h00 |=> in_stall)
        else $error("end word did not start a flush");

    // Blanks are taken without stalling the input
    a_skip_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (in_char == 8'h20 || in_char == 8'h09 || in_char == 8'h0A) |=> !in_stall)
        else $error("blank word stalled the input");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_char),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_char  (out_char),
    .run_last  (run_last),
    .expr_done (expr_done),
    .overflowed(overflowed),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

`default_nettype wire
